// ----- rtl/core/mono_bitmap_blit_oriented_macros.svh -----
// ----------------------------------------------------------------------------
// mono_bitmap_blit_oriented_macros
// assertion macros shared by the bitmap blit design
// ----------------------------------------------------------------------------
`ifndef MONO_BITMAP_BLIT_ORIENTED_MACROS_SVH
`define MONO_BITMAP_BLIT_ORIENTED_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define MBBO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define MBBO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mbbo_pkg.sv -----
// ----------------------------------------------------------------------------
// mbbo_pkg
// types and constants of the monochrome bitmap blit
// ----------------------------------------------------------------------------
`default_nettype none

package mbbo_pkg;

  localparam int PIX_W       = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] REG_BITMAP_WIDTH  = 3'd2;
  localparam logic [2:0] REG_BITMAP_HEIGHT = 3'd3;
  localparam logic [2:0] REG_ORIENTATION   = 3'd4;
  localparam logic [2:0] REG_DRAW_VALUE    = 3'd5;
  localparam logic [2:0] REG_TRANSPARENT   = 3'd6;

  localparam logic [1:0] ORIENT_NONE = 2'd0;
  localparam logic [1:0] ORIENT_90   = 2'd1;
  localparam logic [1:0] ORIENT_180  = 2'd2;
  localparam logic [1:0] ORIENT_270  = 2'd3;

  typedef struct packed {
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [7:0] bitmap_width;
    logic [7:0] bitmap_height;
    logic [1:0] orientation;
    logic       draw_value;
    logic       transparent;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] anchor_x;
    logic [PIX_W-1:0] anchor_y;
    logic [7:0]       column;
    logic             rot;
    logic [7:0]       mask;
    logic [7:0]       value;
    logic             last_byte;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/mbbo_front.sv -----
// ----------------------------------------------------------------------------
// mbbo_front
// takes bitmap bytes, tracks row and column, builds at most one pixel job per byte
// ----------------------------------------------------------------------------
`default_nettype none

module mbbo_front #(
  parameter int COORD_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mbbo_pkg::cfg_t   cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_first_byte,
  input  wire mbbo_pkg::q_stat_t q_stat,
  output logic                  q_push,
  output mbbo_pkg::desc_t       q_push_desc
);
  import mbbo_pkg::*;

  logic [7:0]            col_r, col_nxt;
  logic [7:0]            row_r, row_nxt;
  logic [COORD_BITS-1:0] ax_r, ax_nxt;
  logic [COORD_BITS-1:0] ay_r, ay_nxt;
  logic                  fin_r, fin_nxt;

  logic [COORD_BITS-1:0] ax0, ay0, ax_e, ay_e;
  logic [7:0]            col_e, row_e, row_inc;
  logic                  fin_e, rot, mir, row_end, last_byte, accept;
  logic [7:0]            col_mask, pix_mask;
  logic [8:0]            col_end;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign rot      = cfg.orientation[0];
  assign mir      = cfg.orientation[1];

  always_comb begin
    ax0 = COORD_BITS'(cfg.origin_x);
    ay0 = COORD_BITS'(cfg.origin_y);
    if (cfg.orientation == ORIENT_90) begin
      ax0 = ax0 + COORD_BITS'(cfg.bitmap_width) + COORD_BITS'(1);
    end else if (cfg.orientation == ORIENT_180) begin
      ay0 = ay0 + COORD_BITS'(cfg.bitmap_height) - COORD_BITS'(1);
    end
    col_e = in_first_byte ? 8'd0 : col_r;
    row_e = in_first_byte ? 8'd0 : row_r;
    ax_e  = in_first_byte ? ax0 : ax_r;
    ay_e  = in_first_byte ? ay0 : ay_r;
    fin_e = in_first_byte ? ((cfg.bitmap_width == 8'd0) || (cfg.bitmap_height == 8'd0))
                          : fin_r;

    for (int i = 0; i < 8; i++) begin
      col_mask[i] = ({1'b0, col_e} + 9'(i)) < {1'b0, cfg.bitmap_width};
    end
    pix_mask = col_mask & (in_data_byte | {8{~cfg.transparent}});

    col_end   = {1'b0, col_e} + 9'd8;
    row_end   = col_end >= {1'b0, cfg.bitmap_width};
    row_inc   = row_e + 8'd1;
    last_byte = 1'b0;

    col_nxt = col_e;
    row_nxt = row_e;
    ax_nxt  = ax_e;
    ay_nxt  = ay_e;
    fin_nxt = fin_e;
    if (!fin_e) begin
      if (row_end) begin
        col_nxt = 8'd0;
        row_nxt = row_inc;
        priority case (1'b1)
          mir && rot: ax_nxt = ax_e + COORD_BITS'(1);
          mir:        ay_nxt = ay_e - COORD_BITS'(1);
          rot:        ax_nxt = ax_e - COORD_BITS'(1);
          default:    ay_nxt = ay_e + COORD_BITS'(1);
        endcase
        if ((row_inc >= cfg.bitmap_height) || (row_inc == 8'd0)) begin
          fin_nxt   = 1'b1;
          last_byte = 1'b1;
        end
      end else begin
        col_nxt = col_end[7:0];
      end
    end

    q_push                = accept && !fin_e && (pix_mask != 8'd0);
    q_push_desc.anchor_x  = ax_e[PIX_W-1:0];
    q_push_desc.anchor_y  = ay_e[PIX_W-1:0];
    q_push_desc.column    = col_e;
    q_push_desc.rot       = rot;
    q_push_desc.mask      = pix_mask;
    q_push_desc.value     = in_data_byte ^ {8{~cfg.draw_value}};
    q_push_desc.last_byte = last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ax_r  <= '0;
      ay_r  <= '0;
      fin_r <= 1'b0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ax_r  <= ax_nxt;
      ay_r  <= ay_nxt;
      fin_r <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mbbo_queue.sv -----
// ----------------------------------------------------------------------------
// mbbo_queue
// short fifo of pixel jobs between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module mbbo_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mbbo_pkg::desc_t   push_desc,
  input  wire logic              pop,
  output mbbo_pkg::desc_t        head_desc,
  output mbbo_pkg::q_stat_t      stat
);
  import mbbo_pkg::*;

  desc_t             store_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head_desc  = store_r[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mbbo_back.sv -----
// ----------------------------------------------------------------------------
// mbbo_back
// walks the pixel mask of each job and issues one pixel write per cycle while out_ready does not stall it
// ----------------------------------------------------------------------------
`default_nettype none

module mbbo_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mbbo_pkg::desc_t   head_desc,
  input  wire mbbo_pkg::q_stat_t q_stat,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_pixel_x,
  output logic [7:0]             out_pixel_y,
  output logic                   out_pixel_value,
  output logic                   out_last_of_byte,
  output logic                   out_last_of_bitmap
);
  import mbbo_pkg::*;

  logic       busy_r, busy_nxt;
  logic [7:0] mask_r, mask_nxt;
  desc_t      desc_r, desc_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] px_r, py_r;
  logic       pv_r, plb_r, plbm_r;

  desc_t      src;
  logic [7:0] src_mask, rem, along;
  logic [2:0] idx;
  logic       found, src_valid, slot_free, emit;
  logic [7:0] px_nxt, py_nxt;

  always_comb begin
    src       = busy_r ? desc_r : head_desc;
    src_mask  = busy_r ? mask_r : head_desc.mask;
    src_valid = busy_r || !q_stat.empty;
    slot_free = !out_valid_r || out_ready;
    emit      = slot_free && src_valid;
    q_pop     = emit && !busy_r;

    idx   = 3'd0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && src_mask[i]) begin
        idx   = 3'(i);
        found = 1'b1;
      end
    end
    rem   = src_mask & ~(8'd1 << idx);
    along = src.column + {5'd0, idx};

    px_nxt = src.rot ? src.anchor_x : src.anchor_x + along;
    py_nxt = src.rot ? src.anchor_y + along : src.anchor_y;

    busy_nxt      = emit ? (rem != 8'd0) : busy_r;
    mask_nxt      = emit ? rem : mask_r;
    desc_nxt      = q_pop ? head_desc : desc_r;
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    desc_r <= desc_nxt;
    if (emit) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pv_r   <= src.value[idx];
      plb_r  <= (rem == 8'd0);
      plbm_r <= (rem == 8'd0) && src.last_byte;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_x        = px_r;
  assign out_pixel_y        = py_r;
  assign out_pixel_value    = pv_r;
  assign out_last_of_byte   = plb_r;
  assign out_last_of_bitmap = plbm_r;

endmodule

`default_nettype wire

// ----- rtl/core/mono_bitmap_blit_oriented.sv -----
// first pixel write of a byte is registered in the job queue, then in the output register
// back end issues one pixel write per cycle while out_ready does not stall it: a byte gives 8 writes at most
// a byte with no writes is taken at the input and never reaches the back end
// input stalls only when the two-entry job queue is full
// synchronous active-low reset: counters, queue and output valid cleared, registers to defaults
// ----------------------------------------------------------------------------
// mono_bitmap_blit_oriented
// expands a streamed 1-bit bitmap into oriented pixel writes
// ----------------------------------------------------------------------------
`default_nettype none
`include "mono_bitmap_blit_oriented_macros.svh"

module mono_bitmap_blit_oriented #(
  parameter int COORD_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_first_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_pixel_x,
  output logic [7:0]      out_pixel_y,
  output logic            out_pixel_value,
  output logic            out_last_of_byte,
  output logic            out_last_of_bitmap
);
  import mbbo_pkg::*;

  cfg_t    cfg_r;
  desc_t   push_desc, head_desc;
  q_stat_t q_stat;
  logic    q_push, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= 8'd0;
      cfg_r.origin_y      <= 8'd0;
      cfg_r.bitmap_width  <= 8'd8;
      cfg_r.bitmap_height <= 8'd8;
      cfg_r.orientation   <= ORIENT_NONE;
      cfg_r.draw_value    <= 1'b1;
      cfg_r.transparent   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:      cfg_r.origin_x      <= cfg_wdata;
        REG_ORIGIN_Y:      cfg_r.origin_y      <= cfg_wdata;
        REG_BITMAP_WIDTH:  cfg_r.bitmap_width  <= cfg_wdata;
        REG_BITMAP_HEIGHT: cfg_r.bitmap_height <= cfg_wdata;
        REG_ORIENTATION:   cfg_r.orientation   <= cfg_wdata[1:0];
        REG_DRAW_VALUE:    cfg_r.draw_value    <= cfg_wdata[0];
        REG_TRANSPARENT:   cfg_r.transparent   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  mbbo_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_first_byte(in_first_byte),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_push_desc  (push_desc)
  );

  mbbo_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_desc(push_desc),
    .pop      (q_pop),
    .head_desc(head_desc),
    .stat     (q_stat)
  );

  mbbo_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_desc         (head_desc),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_value   (out_pixel_value),
    .out_last_of_byte  (out_last_of_byte),
    .out_last_of_bitmap(out_last_of_bitmap)
  );

  `MBBO_ASSERT_IMP(a_no_overflow, q_push && !q_pop, !q_stat.full, "job queue overflow")
  `MBBO_ASSERT_IMP(a_no_underflow, q_pop, !q_stat.empty, "job queue underflow")
  `MBBO_ASSERT_IMP(a_end_on_byte, out_valid && out_last_of_bitmap, out_last_of_byte, "bad end")
  `MBBO_ASSERT_NXT(a_push_fills, q_push && !q_pop, !q_stat.empty, "pushed job lost")

endmodule

`default_nettype wire
